@@ hdl/window_slice_start_gather_assert.svh @@
// Assertion macros for the window slice start gatherer checker.
// No dependencies; included by the checker file only.
`ifndef WINDOW_SLICE_START_GATHER_ASSERT_SVH
`define WINDOW_SLICE_START_GATHER_ASSERT_SVH

// same-cycle implication
`define WSSG_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSSG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/wssg_pkg.sv @@
// Package for the window slice start gatherer: widths, register indexes,
// command codes, reset values and the controller state type.
`default_nettype none

package wssg_pkg;

  localparam int TS_W      = 64;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int BIT_CNT_W = $clog2(TS_W);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(TS_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SLIDE = 1'b1;

  localparam logic CMD_RECORD     = 1'b0;
  localparam logic CMD_NEW_BUFFER = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST  = 32'd1000;
  localparam logic [CFG_W-1:0] WINDOW_SLIDE_RST = 32'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEL,
    ST_SEARCH,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ hdl/window_slice_start_gather.sv @@
// Sliding-window slice start gatherer: bit-serial remainder unit, start set
// memory and its scan sequencer. Depends on wssg_pkg.
//
//  channel   handshake                  payload
//  item in   start & !busy              command, timestamp
//  result    strobe (one cycle)         slice_start, overflow
//  config    cfg_valid & cfg_ready      cfg_index, cfg_data
//
// Record: bit-serial remainder (both remainders in parallel, one timestamp
// bit per cycle), a select state, a scan of the set memory through its
// registered read port, then a result strobe that stores the start unless
// the set is full; a match in the set ends the scan with no result.
// New-buffer command empties the set. Synchronous reset clears config to
// 1000 and empties the set; no clearing pass. Results cannot be stalled.
`default_nettype none

module window_slice_start_gather #(
  parameter int SET_CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [wssg_pkg::TS_W-1:0]      timestamp,
  output logic                           strobe,
  output logic [wssg_pkg::TS_W-1:0]      slice_start,
  output logic                           overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wssg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wssg_pkg::CFG_W-1:0]     cfg_data
);
  import wssg_pkg::*;

  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

  state_t state, state_next;

  logic [CFG_W-1:0]     win_size;
  logic [CFG_W-1:0]     win_slide;
  logic [CW-1:0]        count;
  logic [TS_W-1:0]      ts_reg;
  logic [TS_W-1:0]      ts_sh;
  logic [TS_W-1:0]      tm_sh;
  logic                 ge_size;
  logic [CFG_W-1:0]     rem_a;
  logic [CFG_W-1:0]     rem_b;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [TS_W-1:0]      start_val;
  logic [CW-1:0]        scan_idx;
  logic                 rd_vld;
  logic [TS_W-1:0]      rd_data;
  logic [TS_W-1:0]      mem [SET_CAPACITY];

  logic [CFG_W-1:0] slide_eff;
  logic [TS_W:0]    size_diff;
  logic [CFG_W:0]   trial_a, trial_b, sub_a, sub_b;
  logic [CFG_W-1:0] rem_a_next, rem_b_next, sel_rem;
  logic             full, hit, issue;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign strobe    = (state == ST_EMIT);
  assign slice_start = start_val;
  assign full      = (count == CW'(SET_CAPACITY));
  assign overflow  = full;

  // slide of zero behaves as one
  assign slide_eff = (win_slide == '0) ? CFG_W'(1) : win_slide;
  assign size_diff = {1'b0, timestamp} - {{(TS_W - CFG_W + 1){1'b0}}, win_size};

  assign trial_a    = {rem_a, ts_sh[TS_W-1]};
  assign trial_b    = {rem_b, tm_sh[TS_W-1]};
  assign sub_a      = trial_a - {1'b0, slide_eff};
  assign sub_b      = trial_b - {1'b0, slide_eff};
  assign rem_a_next = sub_a[CFG_W] ? trial_a[CFG_W-1:0] : sub_a[CFG_W-1:0];
  assign rem_b_next = sub_b[CFG_W] ? trial_b[CFG_W-1:0] : sub_b[CFG_W-1:0];

  // larger boundary is the one with the smaller remainder
  assign sel_rem = (ge_size && (rem_b < rem_a)) ? rem_b : rem_a;

  assign hit   = rd_vld && (rd_data == start_val);
  assign issue = (state == ST_SEARCH) && (scan_idx < count) && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (command == CMD_RECORD)) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_cnt == LAST_BIT) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (hit) begin
          state_next = ST_IDLE;
        end else if (!issue && !rd_vld) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size  <= WINDOW_SIZE_RST;
      win_slide <= WINDOW_SLIDE_RST;
      count     <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_SIZE:  win_size  <= cfg_data;
          REG_WINDOW_SLIDE: win_slide <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (command == CMD_NEW_BUFFER) begin
              count <= '0;
            end else begin
              ts_reg  <= timestamp;
              ts_sh   <= timestamp;
              tm_sh   <= size_diff[TS_W-1:0];
              ge_size <= !size_diff[TS_W];
              rem_a   <= '0;
              rem_b   <= '0;
              bit_cnt <= '0;
            end
          end
        end
        ST_DIV: begin
          ts_sh   <= {ts_sh[TS_W-2:0], 1'b0};
          tm_sh   <= {tm_sh[TS_W-2:0], 1'b0};
          rem_a   <= rem_a_next;
          rem_b   <= rem_b_next;
          bit_cnt <= bit_cnt + 1'b1;
        end
        ST_SEL: begin
          start_val <= ts_reg - {{(TS_W - CFG_W){1'b0}}, sel_rem};
          scan_idx  <= '0;
          rd_vld    <= 1'b0;
        end
        ST_SEARCH: begin
          rd_vld <= issue;
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!full) begin
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_idx[IW-1:0]];
    if ((state == ST_EMIT) && !full) begin
      mem[count[IW-1:0]] <= start_val;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wssg_checker.sv @@
// Port-level checker for the window slice start gatherer, bound to the top.
// Uses the macros in window_slice_start_gather_assert.svh.
`default_nettype none

`include "window_slice_start_gather_assert.svh"

module wssg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic command,
  input logic strobe
);

  `WSSG_ASSERT_NOW(a_strobe_busy, clk, rst, strobe, busy, "result outside a transaction")
  `WSSG_ASSERT_NEXT(a_one_result, clk, rst, strobe, !strobe && !busy, "more than one result")
  `WSSG_ASSERT_NEXT(a_new_buf, clk, rst, start && !busy && command, !busy && !strobe,
                    "new buffer not single cycle")
  `WSSG_ASSERT_NEXT(a_record_busy, clk, rst, start && !busy && !command, busy && !strobe,
                    "record transaction not taken")

endmodule

bind window_slice_start_gather wssg_checker u_wssg_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .strobe  (strobe)
);

`default_nettype wire
